// ----- design/sensor_frame_deframer_defines.svh -----
// Assertion macros for the deframer
`ifndef SENSOR_FRAME_DEFRAMER_DEFINES_SVH
`define SENSOR_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTH
`define SFD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
`define SFD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");
`else
`define SFD_ASSERT(label, clk, rst, prop)
`define SFD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- design/sfd_pkg.sv -----
package sfd_pkg;

   localparam int BUF_DEPTH     = 128;
   localparam int ADDR_W        = $clog2(BUF_DEPTH);
   localparam int FRAME_BYTES   = 56;
   localparam int CHECKED_BYTES = 53;
   localparam int LEN_VALUE     = 50;
   localparam int SUM_W         = $clog2(CHECKED_BYTES * 255 + 1);
   localparam int NUM_VALUES    = 24;
   localparam int IDX_W         = 5;
   localparam int VALUE_W       = 25;
   localparam int POS_W         = 6;
   localparam int ACC_W         = 24;

   localparam logic [7:0] HDR_FIRST  = 8'hAA;
   localparam logic [7:0] HDR_SECOND = 8'h55;
   localparam logic [7:0] TAIL_BYTE  = 8'hEE;

   typedef struct packed {
      logic byte_take;
      logic start_emit;
      logic issue_read;
      logic shift_in;
      logic next_value;
      logic load_out;
   } sfd_cmd_type;

   typedef struct packed {
      logic rx_enable;
      logic frame_good;
      logic bytes_done;
      logic last_value;
      logic out_free;
   } sfd_status_type;

   function automatic logic [POS_W-1:0] value_start(input logic [IDX_W-1:0] idx);
      logic [POS_W-1:0] pos;
      pos = '0;
      if (idx < IDX_W'(9)) begin
         pos = POS_W'(3) + {idx[POS_W-2:0], 1'b0};
      end else if (idx >= IDX_W'(15) && idx < IDX_W'(23)) begin
         pos = POS_W'(35) + {(idx[POS_W-2:0] - (POS_W-1)'(15)), 1'b0};
      end else begin
         unique case (idx)
            IDX_W'(9):  pos = POS_W'(24);
            IDX_W'(10): pos = POS_W'(21);
            IDX_W'(11): pos = POS_W'(27);
            IDX_W'(12): pos = POS_W'(31);
            IDX_W'(13): pos = POS_W'(29);
            IDX_W'(14): pos = POS_W'(33);
            default:    pos = POS_W'(51);
         endcase
      end
      return pos;
   endfunction

   function automatic logic value_wide(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(9)) || (idx == IDX_W'(10));
   endfunction

   function automatic logic value_neg(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(10)) || (idx == IDX_W'(13));
   endfunction

endpackage

// ----- design/sensor_frame_deframer.sv -----
// Serial frame deframer. Takes one received byte per beat on req_ while reception is
// enabled (csr_receive_enable, reset 1) and stores it in a 128-byte frame buffer; AA 55
// empties the buffer and EE EE closes a frame. A 56-byte frame with length byte 50 and a
// matching mean-checksum byte is read out as 24 sign-extended values on rsp_, indices 10
// and 13 negated and index 23 flagged by rsp_last. A byte that closes no good frame does
// not stall req_. After a good frame req_stall stays high while the readout runs off the
// single read port of the frame buffer, one stored byte at a time, and waits while
// rsp_stall holds a pending value on rsp_. The buffer needs no clearing after reset.
module sensor_frame_deframer import sfd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_rx_byte,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_receive_enable,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [IDX_W-1:0]          rsp_value_index,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic                      rsp_last
);

   sfd_cmd_type    cmd;
   sfd_status_type status;

   sfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sfd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_rx_byte        (req_rx_byte),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_receive_enable (csr_receive_enable),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_value_index    (rsp_value_index),
      .rsp_value          (rsp_value),
      .rsp_last           (rsp_last)
   );

endmodule

// ----- design/sfd_ctrl.sv -----
`include "sensor_frame_deframer_defines.svh"

module sfd_ctrl import sfd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  sfd_status_type status,
   output sfd_cmd_type    cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            cmd.byte_take = req_valid && status.rx_enable;
            if (cmd.byte_take && status.frame_good) begin
               cmd.start_emit = 1'b1;
               state_in       = S_READ;
            end
         end
         S_READ: begin
            cmd.issue_read = 1'b1;
            state_in       = S_SHIFT;
         end
         S_SHIFT: begin
            cmd.shift_in = 1'b1;
            state_in     = status.bytes_done ? S_EMIT : S_READ;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.last_value) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.next_value = 1'b1;
                  state_in       = S_READ;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SFD_ASSERT(a_load_needs_room, clock, reset, cmd.load_out |-> status.out_free)
   `SFD_ASSERT(a_start_stalls, clock, reset, cmd.start_emit |=> req_stall)
   `SFD_ASSERT(a_final_returns, clock, reset,
      (state_ff == S_EMIT && status.out_free && status.last_value) |=> !req_stall)

endmodule

// ----- design/sfd_datapath.sv -----
`include "sensor_frame_deframer_defines.svh"

module sfd_datapath import sfd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [7:0]                req_rx_byte,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_receive_enable,
   input  sfd_cmd_type               cmd,
   output sfd_status_type            status,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [IDX_W-1:0]          rsp_value_index,
   output logic signed [VALUE_W-1:0] rsp_value,
   output logic                      rsp_last
);

   logic [7:0]         frame_mem [BUF_DEPTH];
   logic               rx_enable_ff;
   logic [ADDR_W-1:0]  count_ff;
   logic [ADDR_W-1:0]  count_in;
   logic [7:0]         prev_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [SUM_W-1:0]   sum_in;
   logic [7:0]         len_ff;
   logic [7:0]         chk_ff;
   logic [7:0]         rd_data_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [1:0]         bcnt_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic               rsp_valid_ff;
   logic [IDX_W-1:0]   rsp_value_index_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_last_ff;

   logic               hdr_hit;
   logic               tail_hit;
   logic               wrap_hit;
   logic [SUM_W-1:0]   chk_prod;
   logic               sum_ok;
   logic [ADDR_W-1:0]  rd_addr;
   logic [VALUE_W-1:0] raw_val;
   logic [VALUE_W-1:0] out_val;

   assign csr_ready = 1'b1;

   assign hdr_hit  = (count_ff != '0) && (prev_ff == HDR_FIRST) && (req_rx_byte == HDR_SECOND);
   assign tail_hit = (count_ff >= ADDR_W'(3)) && (prev_ff == TAIL_BYTE)
                     && (req_rx_byte == TAIL_BYTE);
   assign wrap_hit = (count_ff == ADDR_W'(BUF_DEPTH - 1));
   assign chk_prod = SUM_W'(chk_ff) * SUM_W'(CHECKED_BYTES);
   assign sum_ok   = (sum_ff >= chk_prod)
                     && ({1'b0, sum_ff} < ({1'b0, chk_prod} + (SUM_W+1)'(CHECKED_BYTES)));

   always_comb begin
      count_in = count_ff + ADDR_W'(1);
      sum_in   = sum_ff;
      if (count_ff < ADDR_W'(CHECKED_BYTES)) begin
         sum_in = sum_ff + SUM_W'(req_rx_byte);
      end
      if (hdr_hit || tail_hit || wrap_hit) begin
         count_in = '0;
         sum_in   = '0;
      end
   end

   assign rd_addr = ADDR_W'(value_start(idx_ff)) + ADDR_W'(bcnt_ff);
   assign raw_val = value_wide(idx_ff) ? {acc_ff[ACC_W-1], acc_ff}
                                       : {{(VALUE_W-16){acc_ff[15]}}, acc_ff[15:0]};
   assign out_val = value_neg(idx_ff) ? (~raw_val + VALUE_W'(1)) : raw_val;

   assign status.rx_enable  = rx_enable_ff;
   assign status.frame_good = (count_ff == ADDR_W'(FRAME_BYTES - 1)) && tail_hit
                              && (len_ff == 8'(LEN_VALUE)) && sum_ok;
   assign status.bytes_done = (bcnt_ff == (value_wide(idx_ff) ? 2'd3 : 2'd2));
   assign status.last_value = (idx_ff == IDX_W'(NUM_VALUES - 1));
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.byte_take) begin
         frame_mem[count_ff] <= req_rx_byte;
      end
      if (cmd.issue_read) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_enable_ff <= 1'b1;
         count_ff     <= '0;
         sum_ff       <= '0;
         idx_ff       <= '0;
         bcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            rx_enable_ff <= csr_receive_enable;
         end
         if (cmd.byte_take) begin
            count_ff <= count_in;
            sum_ff   <= sum_in;
         end
         if (cmd.start_emit || cmd.next_value) begin
            bcnt_ff <= '0;
         end else if (cmd.issue_read) begin
            bcnt_ff <= bcnt_ff + 2'd1;
         end
         if (cmd.start_emit) begin
            idx_ff <= '0;
         end else if (cmd.next_value) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.byte_take) begin
         prev_ff <= req_rx_byte;
         if (count_ff == ADDR_W'(2)) begin
            len_ff <= req_rx_byte;
         end
         if (count_ff == ADDR_W'(CHECKED_BYTES)) begin
            chk_ff <= req_rx_byte;
         end
      end
      if (cmd.shift_in) begin
         acc_ff <= {acc_ff[ACC_W-9:0], rd_data_ff};
      end
      if (cmd.load_out) begin
         rsp_value_index_ff <= idx_ff;
         rsp_value_ff       <= out_val;
         rsp_last_ff        <= status.last_value;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value_index = rsp_value_index_ff;
   assign rsp_value       = signed'(rsp_value_ff);
   assign rsp_last        = rsp_last_ff;

   `SFD_ASSERT(a_start_clears, clock, reset, cmd.start_emit |=> (count_ff == '0 && sum_ff == '0))
   `SFD_ASSERT(a_last_on_final, clock, reset,
      cmd.load_out |=> (rsp_last_ff == (rsp_value_index_ff == IDX_W'(NUM_VALUES - 1))))

endmodule

// ----- tb/sv/frame_value_checker.sv -----
`timescale 1ns / 100ps

module frame_value_checker import sfd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [7:0]                req_rx_byte,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic                      csr_receive_enable,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [IDX_W-1:0]          rsp_value_index,
   input  logic signed [VALUE_W-1:0] rsp_value,
   input  logic                      rsp_last,
   output int                        fail_count,
   output int                        expected_left
);

   typedef struct {
      logic [IDX_W-1:0]          index;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } decoded_value_type;

   decoded_value_type values_due[$];
   logic [7:0]        frame_store [0:BUF_DEPTH-1];
   int                stored;
   logic              rx_on;
   int                failures = 0;

   function automatic logic signed [VALUE_W-1:0] be16(input int pos);
      logic signed [15:0] raw;
      raw = {frame_store[pos], frame_store[pos+1]};
      return raw;
   endfunction

   function automatic logic signed [VALUE_W-1:0] be24(input int pos);
      logic signed [23:0] raw;
      raw = {frame_store[pos], frame_store[pos+1], frame_store[pos+2]};
      return raw;
   endfunction

   function automatic logic frame_passes();
      int total;
      total = 0;
      if (stored != FRAME_BYTES) return 1'b0;
      if (frame_store[2] != LEN_VALUE) return 1'b0;
      for (int i = 0; i < CHECKED_BYTES; i++) total += frame_store[i];
      return ((total / CHECKED_BYTES) & 8'hFF) == frame_store[CHECKED_BYTES];
   endfunction

   function automatic void release_frame();
      logic signed [VALUE_W-1:0] v [0:NUM_VALUES-1];
      decoded_value_type item;
      for (int i = 0; i < 3; i++) begin
         v[i]     = be16(3 + 2 * i);
         v[3 + i] = be16(9 + 2 * i);
         v[6 + i] = be16(15 + 2 * i);
      end
      // odometry axes swapped
      v[9]  = be24(24);
      v[10] = -be24(21);
      v[11] = be16(27);
      v[12] = be16(31);
      v[13] = -be16(29);
      v[14] = be16(33);
      for (int i = 0; i < 8; i++) v[15 + i] = be16(35 + 2 * i);
      v[23] = be16(51);
      for (int i = 0; i < NUM_VALUES; i++) begin
         item.index = IDX_W'(i);
         item.value = v[i];
         item.last  = (i == NUM_VALUES - 1);
         values_due.push_back(item);
      end
   endfunction

   function automatic void absorb_byte(input logic [7:0] b);
      if (!rx_on) return;
      if (stored >= BUF_DEPTH) stored = 0;
      frame_store[stored] = b;
      stored++;
      if (stored > 1) begin
         if (frame_store[stored-2] == HDR_FIRST && frame_store[stored-1] == HDR_SECOND) begin
            stored = 0;
         end else if (stored > 3 && frame_store[stored-2] == TAIL_BYTE &&
                      frame_store[stored-1] == TAIL_BYTE) begin
            if (frame_passes()) release_frame();
            stored = 0;
         end
      end
      if (stored >= BUF_DEPTH) stored = 0;
   endfunction

   always @(posedge clock) begin : watch
      decoded_value_type want;
      if (reset) begin
         values_due.delete();
         stored = 0;
         rx_on  = 1'b1;
      end else begin
         if (csr_valid && csr_ready) rx_on = csr_receive_enable;
         if (req_valid && !req_stall) absorb_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            if (values_due.size() == 0) begin
               if (failures < 10)
                  $display("unexpected beat: index %0d value %0d last %0b",
                           rsp_value_index, rsp_value, rsp_last);
               failures++;
            end else begin
               want = values_due.pop_front();
               if (want.index !== rsp_value_index || want.value !== rsp_value ||
                   want.last !== rsp_last) begin
                  if (failures < 10)
                     $display("mismatch: expected index/value/last %0d/%0d/%0b, got %0d/%0d/%0b",
                              want.index, want.value, want.last,
                              rsp_value_index, rsp_value, rsp_last);
                  failures++;
               end
            end
         end
      end
      expected_left <= values_due.size();
      fail_count    <= failures;
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench import sfd_pkg::*;;

   localparam int SETTLE_CYCLES = 140;

   typedef enum {PAT_RANDOM, PAT_ZERO, PAT_ONES, PAT_MIN, PAT_MAX} pattern_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [7:0]                req_rx_byte;
   logic                      csr_valid;
   logic                      csr_ready;
   logic                      csr_receive_enable;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [IDX_W-1:0]          rsp_value_index;
   logic signed [VALUE_W-1:0] rsp_value;
   logic                      rsp_last;
   int                        fail_count;
   int                        expected_left;

   logic [7:0] frame_bytes [0:FRAME_BYTES-1];
   int         bytes_sent = 0;
   logic       quiet = 1'b0;

   sensor_frame_deframer uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_receive_enable (csr_receive_enable),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_value_index    (rsp_value_index),
      .rsp_value          (rsp_value),
      .rsp_last           (rsp_last)
   );

   frame_value_checker value_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_receive_enable (csr_receive_enable),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_value_index    (rsp_value_index),
      .rsp_value          (rsp_value),
      .rsp_last           (rsp_last),
      .fail_count         (fail_count),
      .expected_left      (expected_left)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 6);
         repeat (hold) @(posedge clock);
         rsp_stall <= 1'b1;
         hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
         repeat (hold) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [7:0] biased_byte();
      logic [7:0] picks [0:6];
      picks = '{8'hAA, 8'h55, 8'hEE, 8'h00, 8'hFF, 8'h80, 8'h7F};
      if ($urandom_range(0, 7) == 0) return picks[$urandom_range(0, 6)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic bad_pair(input logic [7:0] a, input logic [7:0] b);
      return (a == HDR_FIRST && b == HDR_SECOND) || (a == TAIL_BYTE && b == TAIL_BYTE);
   endfunction

   function automatic logic is_field_start(input int p);
      return p == 24 || (p % 2 == 1 && p != 23 && p != 25);
   endfunction

   function automatic void make_frame(input pattern_type kind);
      int         total;
      logic [7:0] b;
      frame_bytes[2] = 8'(LEN_VALUE);
      for (int p = 3; p < CHECKED_BYTES; p++) begin
         case (kind)
            PAT_ZERO: b = 8'h00;
            PAT_ONES: b = 8'hFF;
            PAT_MIN:  b = is_field_start(p) ? 8'h80 : 8'h00;
            PAT_MAX:  b = is_field_start(p) ? 8'h7F : 8'hFF;
            default: begin
               b = biased_byte();
               while (bad_pair(frame_bytes[p-1], b)) b = biased_byte();
            end
         endcase
         frame_bytes[p] = b;
      end
      // pick the two leading bytes so the check byte cannot fake a tail or header
      do begin
         frame_bytes[0] = biased_byte();
         frame_bytes[1] = biased_byte();
         total = 0;
         for (int p = 0; p < CHECKED_BYTES; p++) total += frame_bytes[p];
         frame_bytes[CHECKED_BYTES] = 8'(total / CHECKED_BYTES);
      end while (bad_pair(frame_bytes[0], frame_bytes[1]) ||
                 frame_bytes[CHECKED_BYTES] == TAIL_BYTE ||
                 bad_pair(frame_bytes[CHECKED_BYTES-1], frame_bytes[CHECKED_BYTES]));
      frame_bytes[FRAME_BYTES-2] = TAIL_BYTE;
      frame_bytes[FRAME_BYTES-1] = TAIL_BYTE;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      int r;
      r = $urandom_range(0, 99);
      gap = (quiet || r < 65) ? 0 : (r < 94) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_span(input int from, input int upto);
      for (int p = from; p < upto; p++) send_byte(frame_bytes[p]);
   endtask

   task automatic send_header();
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
   endtask

   task automatic drain(input logic settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_enable(input logic en);
      csr_valid          <= 1'b1;
      csr_receive_enable <= en;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int target;
      int r;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_rx_byte        <= 8'h00;
      csr_valid          <= 1'b0;
      csr_receive_enable <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_enable(1'b1);

      quiet = 1'b1;
      make_frame(PAT_MIN);
      send_header();
      send_span(0, FRAME_BYTES);

      // fill the buffer to capacity so the count wraps
      send_header();
      for (int i = 0; i < BUF_DEPTH; i++) send_byte(8'(i % 100));
      make_frame(PAT_MAX);
      send_span(0, FRAME_BYTES);
      quiet = 1'b0;

      // tail too early to close a frame, then a short reject
      send_header();
      repeat (4) send_byte(TAIL_BYTE);

      // restart by header partway through a frame
      make_frame(PAT_RANDOM);
      send_span(0, 12);
      send_header();
      make_frame(PAT_ZERO);
      send_span(0, FRAME_BYTES);

      // drop bytes mid-frame while reception is off
      make_frame(PAT_ONES);
      send_span(0, 30);
      drain(1'b1);
      write_enable(1'b0);
      send_header();
      repeat (4) send_byte(biased_byte());
      send_byte(TAIL_BYTE);
      send_byte(TAIL_BYTE);
      drain(1'b1);
      write_enable(1'b1);
      send_span(30, FRAME_BYTES);

      target = bytes_sent + 60;
      while (bytes_sent < target) begin
         r = $urandom_range(0, 99);
         quiet = ($urandom_range(0, 3) == 0);
         make_frame(PAT_RANDOM);
         if (r < 55) begin
            if ($urandom_range(0, 1)) send_header();
            send_span(0, FRAME_BYTES);
         end else if (r < 63) begin
            send_header();
            frame_bytes[2] = 8'(LEN_VALUE + $urandom_range(1, 255));
            send_span(0, FRAME_BYTES);
         end else if (r < 71) begin
            send_header();
            frame_bytes[CHECKED_BYTES] = frame_bytes[CHECKED_BYTES] ^
                                         8'($urandom_range(1, 255));
            send_span(0, FRAME_BYTES);
         end else if (r < 77) begin
            send_header();
            if ($urandom_range(0, 1)) begin
               send_span(0, 20);
               send_span(21, FRAME_BYTES);
            end else begin
               send_span(0, 30);
               send_byte(biased_byte());
               send_span(30, FRAME_BYTES);
            end
         end else if (r < 83) begin
            send_header();
            send_span(0, $urandom_range(3, 50));
            send_header();
            send_span(0, FRAME_BYTES);
         end else begin
            repeat ($urandom_range(1, 12)) send_byte(biased_byte());
         end
      end
      drain(1'b1);
      write_enable(1'b0);
      quiet = 1'b0;
      repeat ($urandom_range(3, 8)) send_byte(biased_byte());
      drain(1'b1);
      write_enable(1'b1);

      drain(1'b0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_left == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
